// ===== rtl/asm_pkg.sv =====
// Package for the angular scan min-merge block.
// Holds the sequencer state type, op codes and payload types; no dependencies.
package asm_pkg;

  typedef logic [15:0]        range_t;
  typedef logic signed [15:0] angle_in_t;
  typedef logic [11:0]        beam_t;
  typedef logic [9:0]         bin_sel_t;
  typedef logic [10:0]        bins_cfg_t;

  localparam logic OP_MERGE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam bins_cfg_t BINS_RESET = 11'd360;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANGLE,
    ST_SCALE,
    ST_FETCH,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/asm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module asm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/angular_scan_min_merge.sv =====
// Angular scan min-merge: keeps the nearest valid range per angular bin.
// After reset a clearing pass zeroes every bin memory entry, with busy high.
// A read beat passes through the fetch and update states; its result then strobes on done.
// An in-range merge beat keeps busy high through the angle, scale, fetch and update states.
// One beat at a time: the bin memory read-modify-write sets the rate; done cannot stall.
// Depends on asm_pkg and asm_ram.
module angular_scan_min_merge #(
  parameter int MAX_BINS   = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_write,
  input  asm_pkg::bins_cfg_t   cfg_data,
  input  logic                 op,
  input  asm_pkg::range_t      beam_range,
  input  asm_pkg::range_t      valid_low,
  input  asm_pkg::range_t      valid_high,
  input  asm_pkg::angle_in_t   start_angle,
  input  asm_pkg::range_t      angle_step,
  input  asm_pkg::beam_t       beam_number,
  input  asm_pkg::bin_sel_t    read_bin,
  output logic                 done,
  output asm_pkg::range_t      bin_value,
  output asm_pkg::bin_sel_t    bin_number
);
  import asm_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int BW = $clog2(MAX_BINS + 1);
  localparam int PW = ANGLE_BITS + BW;
  localparam logic [PW-1:0] HALF = PW'(1) << (ANGLE_BITS - 1);

  state_t state, state_next;

  bins_cfg_t       bins_in_use;
  logic [BW-1:0]   bins_eff;
  logic [AW-1:0]   clr_addr;

  logic            op_q;
  range_t          range_q;
  angle_in_t       start_q;
  range_t          step_q;
  beam_t           beam_q;
  bin_sel_t        read_bin_q;
  logic            oob_q;
  logic            in_range;

  logic [27:0]           beam_prod;
  logic [ANGLE_BITS-1:0] angle;
  logic [PW-1:0]         scaled;
  logic [BW-1:0]         bin_raw;
  logic [AW-1:0]         bin_idx;
  logic [AW-1:0]         addr_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  range_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  range_t          ram_rdata;

  always_comb begin
    if (bins_in_use == '0) begin
      bins_eff = BW'(1);
    end else if (32'(bins_in_use) > 32'(MAX_BINS)) begin
      bins_eff = BW'(MAX_BINS);
    end else begin
      bins_eff = BW'(bins_in_use);
    end
  end

  assign in_range  = (beam_range > valid_low) && (beam_range < valid_high);
  assign beam_prod = 28'(beam_q) * 28'(step_q);
  assign bin_raw   = scaled[PW-1:ANGLE_BITS];
  assign bin_idx   = (bin_raw >= bins_eff) ? '0 : AW'(bin_raw);
  assign busy      = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (op == OP_READ) begin
            state_next = ST_FETCH;
          end else if (in_range) begin
            state_next = ST_ANGLE;
          end
        end
      end
      ST_ANGLE:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = (op_q == OP_READ) ? AW'(read_bin_q) : bin_idx;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_UPDATE: begin
        if (op_q == OP_READ) begin
          ram_we = !oob_q;
        end else begin
          ram_we    = (ram_rdata == '0) || (ram_rdata > range_q);
          ram_wdata = range_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      bins_in_use <= BINS_RESET;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE) && (op_q == OP_READ);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write) begin
        bins_in_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_q       <= op;
      range_q    <= beam_range;
      start_q    <= start_angle;
      step_q     <= angle_step;
      beam_q     <= beam_number;
      read_bin_q <= read_bin;
      oob_q      <= (32'(read_bin) >= 32'(bins_eff));
    end
    if (state == ST_ANGLE) begin
      angle <= ANGLE_BITS'(start_q) + beam_prod[ANGLE_BITS-1:0];
    end
    if (state == ST_SCALE) begin
      scaled <= PW'(angle) * PW'(bins_eff) + HALF;
    end
    if (state == ST_FETCH) begin
      addr_q <= ram_raddr;
    end
    if (state == ST_UPDATE) begin
      bin_value  <= oob_q ? '0 : ram_rdata;
      bin_number <= read_bin_q;
    end
  end

  asm_ram #(
    .WIDTH(16),
    .DEPTH(MAX_BINS)
  ) u_bin_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
